### rtl/ppoc_pkg.sv
// Shared types, register indexes and pipeline constants for the point projection block.
// No dependencies; imported by the top level and its checker.
package ppoc_pkg;

  localparam int DEF_SPACE_DIMS = 2;
  localparam int MAX_DIMS       = 3;

  // Configuration register indexes
  localparam logic [2:0] REG_CENTRE_X  = 3'd0;
  localparam logic [2:0] REG_CENTRE_Y  = 3'd1;
  localparam logic [2:0] REG_CENTRE_Z  = 3'd2;
  localparam logic [2:0] REG_RADIUS    = 3'd3;
  localparam logic [2:0] REG_MAX_DIST  = 3'd4;

  // Arithmetic widths
  localparam int MAG_W  = 33;  // |p - c|
  localparam int SQ_W   = 66;  // square of one difference
  localparam int SUM_W  = 68;  // sum of squares, padded to even for the root
  localparam int ROOT_W = 34;  // floor square root
  localparam int PROD_W = 63;  // |d| * R
  localparam int NUM_W  = 65;  // 2*prod + r
  localparam int DEN_W  = 35;  // 2*r
  localparam int QUO_W  = 33;  // rounded quotient

  // Pipeline shape
  localparam int SQ_STEPS  = ROOT_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int CTX_DEPTH = 5 + SQ_STEPS + DIV_STEPS;
  localparam int PIPE_LAT  = CTX_DEPTH + 1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               moved;
    logic               within_band;
    logic               at_centre;
  } res_t;

  // Per-item context that travels down the pipeline
  typedef struct packed {
    pos_t                          pos;
    logic [MAX_DIMS-1:0]           neg;
    logic [MAX_DIMS-1:0][MAG_W-1:0] mag;
    logic                          zero;
    logic                          in_band;
    logic                          moved;
    logic [ROOT_W-1:0]             r;
  } ctx_t;

  function automatic logic signed [31:0] get_coord(input pos_t p, input int idx);
    logic signed [31:0] v;
    v = p.pos_x;
    if (idx == 1) v = p.pos_y;
    if (idx == 2) v = p.pos_z;
    return v;
  endfunction

endpackage

### rtl/point_projection_onto_circle.sv
// Top level: radial projection of a Q16.16 point onto a circle or sphere.
// Depends on ppoc_pkg; fully pipelined datapath in one module.
//
//   channel | ports                          | transfer
//   input   | start, busy, in_data (pos_t)   | start && !busy at a rising edge
//   result  | out_valid, out_data (res_t)    | out_valid high for one cycle
//   config  | cfg_we, cfg_idx, cfg_wdata     | cfg_we at a rising edge
//
// One item per cycle once busy is low; results leave in the order of their input transfers.
// The depth is set by the 34-step bit-serial root and the 33-step restoring divider,
// one step per stage. busy is high during reset and for the first cycle after it.
// Synchronous reset clears valid bits and loads the default registers.
// The receiver cannot stall, so the pipeline never holds.
module point_projection_onto_circle
  import ppoc_pkg::*;
#(
  parameter int SPACE_DIMS = DEF_SPACE_DIMS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  pos_t        in_data,
  output logic        out_valid,
  output res_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  // Context stages where fields are filled in
  localparam int ZERO_STG = 2;
  localparam int BAND_STG = 3 + SQ_STEPS;

  logic signed [31:0] cen_r [MAX_DIMS];
  logic [30:0]        radius_r;
  logic [30:0]        maxd_r;
  logic               busy_r;

  ctx_t               ctx_r [CTX_DEPTH];
  logic               v_r   [CTX_DEPTH];
  logic               out_valid_r;
  res_t               out_data_r;

  logic [SQ_W-1:0]    sq_r   [SPACE_DIMS];
  logic [SUM_W-1:0]   sx_nxt;
  logic [SUM_W-1:0]   sx_r   [SQ_STEPS+1];
  logic [SUM_W-1:0]   sres_r [SQ_STEPS+1];
  logic [PROD_W-1:0]  prod_r [SPACE_DIMS];
  logic [NUM_W-1:0]   rem_r  [DIV_STEPS+1][SPACE_DIMS];
  logic [QUO_W-1:0]   q_r    [DIV_STEPS+1][SPACE_DIMS];
  logic [DEN_W-1:0]   den_r  [DIV_STEPS+1];

  logic               in_acc;

  assign in_acc    = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      cen_r[0] <= '0;
      cen_r[1] <= '0;
      cen_r[2] <= '0;
      radius_r <= 31'd65536;
      maxd_r   <= 31'd65536;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_CENTRE_X: cen_r[0] <= cfg_wdata;
          REG_CENTRE_Y: cen_r[1] <= cfg_wdata;
          REG_CENTRE_Z: cen_r[2] <= cfg_wdata;
          REG_RADIUS:   radius_r <= cfg_wdata[30:0];
          REG_MAX_DIST: maxd_r   <= cfg_wdata[30:0];
          default: ;
        endcase
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < CTX_DEPTH; n++) v_r[n] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_r[0] <= in_acc;
      for (int n = 1; n < CTX_DEPTH; n++) v_r[n] <= v_r[n-1];
      out_valid_r <= v_r[CTX_DEPTH-1];
    end
  end

  // Stage 1 and the context shift line, with fields filled in where they are computed
  always_ff @(posedge clk) begin
    ctx_t c;
    ctx_t cz;
    ctx_t cb;
    logic signed [MAG_W-1:0] d;
    logic signed [ROOT_W:0] dev;
    logic [ROOT_W:0]        adev;
    // differences from the centre
    c = '0;
    c.pos = in_data;
    for (int i = 0; i < SPACE_DIMS; i++) begin
      d = MAG_W'(get_coord(in_data, i)) - MAG_W'(cen_r[i]);
      c.neg[i] = d[MAG_W-1];
      c.mag[i] = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
    end
    ctx_r[0] <= c;
    for (int n = 1; n < CTX_DEPTH; n++) begin
      if (n != ZERO_STG && n != BAND_STG) ctx_r[n] <= ctx_r[n-1];
    end
    // at-centre flag from the sum of squares
    cz      = ctx_r[ZERO_STG-1];
    cz.zero = (sx_nxt == '0);
    ctx_r[ZERO_STG] <= cz;
    // band test on the finished root
    cb     = ctx_r[BAND_STG-1];
    cb.r   = sres_r[SQ_STEPS][ROOT_W-1:0];
    dev    = $signed({1'b0, cb.r}) - $signed({4'b0, radius_r});
    adev   = dev[ROOT_W] ? (ROOT_W+1)'(-dev) : (ROOT_W+1)'(dev);
    cb.in_band = adev <= {4'b0, maxd_r};
    cb.moved   = !cb.zero && !cb.in_band;
    ctx_r[BAND_STG] <= cb;
  end

  // Stage 2: squares; stage 3: sum
  always_comb begin
    sx_nxt = '0;
    for (int i = 0; i < SPACE_DIMS; i++) sx_nxt = sx_nxt + SUM_W'(sq_r[i]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SPACE_DIMS; i++) begin
      // |d| is at most 2^32, so the top bit set means the low part is zero
      sq_r[i] <= ctx_r[0].mag[i][MAG_W-1] ? (SQ_W'(1) << 64)
               : SQ_W'(ctx_r[0].mag[i][31:0] * ctx_r[0].mag[i][31:0]);
    end
    sx_r[0]   <= sx_nxt;
    sres_r[0] <= '0;
  end

  // Bit-serial square root, one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << (SUM_W - 2 - 2*k);
    logic [SUM_W-1:0] tst;
    assign tst = sres_r[k] + ONE;
    always_ff @(posedge clk) begin
      if (sx_r[k] >= tst) begin
        sx_r[k+1]   <= sx_r[k] - tst;
        sres_r[k+1] <= (sres_r[k] >> 1) + ONE;
      end else begin
        sx_r[k+1]   <= sx_r[k];
        sres_r[k+1] <= sres_r[k] >> 1;
      end
    end
  end

  // Band stage: products |d| * R
  always_ff @(posedge clk) begin
    for (int i = 0; i < SPACE_DIMS; i++) begin
      prod_r[i] <= ctx_r[36].mag[i][MAG_W-1] ? {radius_r, 32'b0}
                 : PROD_W'(ctx_r[36].mag[i][31:0] * radius_r);
    end
  end

  // Divider set-up: numerator 2*prod + r, divisor 2*r
  always_ff @(posedge clk) begin
    for (int i = 0; i < SPACE_DIMS; i++) begin
      rem_r[0][i] <= {prod_r[i], 1'b0} + NUM_W'(ctx_r[37].r);
      q_r[0][i]   <= '0;
    end
    den_r[0] <= {ctx_r[37].r, 1'b0};
  end

  // Restoring divider, one quotient bit per stage
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - s;
    logic [NUM_W+1:0] dsh;
    assign dsh = (NUM_W+2)'(den_r[s]) << SH;
    always_ff @(posedge clk) begin
      for (int i = 0; i < SPACE_DIMS; i++) begin
        if ({2'b0, rem_r[s][i]} >= dsh) begin
          rem_r[s+1][i] <= NUM_W'({2'b0, rem_r[s][i]} - dsh);
          q_r[s+1][i]   <= q_r[s][i] | (QUO_W'(1) << SH);
        end else begin
          rem_r[s+1][i] <= rem_r[s][i];
          q_r[s+1][i]   <= q_r[s][i];
        end
      end
      den_r[s+1] <= den_r[s];
    end
  end

  // Output stage: centre +/- quotient, saturated, for a moved point; otherwise the input point passes
  always_ff @(posedge clk) begin
    ctx_t c;
    res_t o;
    logic signed [34:0] v;
    logic signed [31:0] sat [MAX_DIMS];
    c = ctx_r[CTX_DEPTH-1];
    sat[0] = c.pos.pos_x;
    sat[1] = c.pos.pos_y;
    sat[2] = c.pos.pos_z;
    if (c.moved) begin
      for (int i = 0; i < SPACE_DIMS; i++) begin
        v = c.neg[i] ? 35'(cen_r[i]) - $signed({2'b0, q_r[DIV_STEPS][i]})
                     : 35'(cen_r[i]) + $signed({2'b0, q_r[DIV_STEPS][i]});
        if (v > 35'sd2147483647)       sat[i] = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648) sat[i] = 32'sh80000000;
        else                           sat[i] = v[31:0];
      end
    end
    o.out_x       = sat[0];
    o.out_y       = sat[1];
    o.out_z       = sat[2];
    o.moved       = c.moved;
    o.within_band = c.in_band;
    o.at_centre   = c.zero;
    out_data_r <= o;
  end

endmodule

### rtl/ppoc_checker.sv
// Port-level checker for the point projection block, with its bind.
// Depends on ppoc_pkg for the result type and pipeline latency.
module ppoc_checker
  import ppoc_pkg::*;
#(
  parameter int SPACE_DIMS = DEF_SPACE_DIMS
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input pos_t        in_data,
  input logic        out_valid,
  input res_t        out_data
);

  // A result always stems from a transfer a fixed latency earlier
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching input transfer");

  // A moved point lay outside the band and away from the centre
  a_moved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.moved |-> !out_data.at_centre && !out_data.within_band)
    else $error("moved flag inconsistent with band flags");

  // An unmoved point leaves unchanged
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.moved |->
      out_data.out_x == $past(in_data.pos_x, PIPE_LAT) &&
      out_data.out_y == $past(in_data.pos_y, PIPE_LAT) &&
      out_data.out_z == $past(in_data.pos_z, PIPE_LAT))
    else $error("unmoved point altered");

  // In two dimensions z is always passed through
  a_z2d: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (SPACE_DIMS == 2) |-> out_data.out_z == $past(in_data.pos_z, PIPE_LAT))
    else $error("z altered in two dimensions");

endmodule

bind point_projection_onto_circle ppoc_checker #(.SPACE_DIMS(SPACE_DIMS)) u_ppoc_checker (.*);

### sim/tb_point_projection_onto_circle.sv
// Self-checking testbench for point_projection_onto_circle: directed table, extreme settings, then random bursts.
// Depends on ppoc_pkg and the RTL top level; a local projection predictor gives the expected results of untyped items.
module tb_point_projection_onto_circle;
  import ppoc_pkg::*;

  localparam int DIMS      = DEF_SPACE_DIMS;
  localparam int IDLE_MAX  = 4000;
  localparam int N_PHASES  = 5;
  localparam int PHASE_LEN = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  pos_t        in_data = '0;
  logic        out_valid;
  res_t        out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = REG_CENTRE_X;
  logic [31:0] cfg_wdata = '0;

  // Shadow copy of the block's registers
  logic signed [31:0] cen_x, cen_y, cen_z;
  logic [30:0]        radius, band;

  res_t pending_q[$];
  int   err_cnt = 0;
  int   idle_cnt = 0;

  typedef struct {
    pos_t p;
    bit   typed;
    res_t r;
  } row_t;
  row_t rows[$];

  point_projection_onto_circle #(.SPACE_DIMS(DIMS)) DUT (.*);

  always #10 clk = ~clk;

  // Projection predictor at the block's widths
  function automatic res_t project_point(pos_t p);
    logic signed [31:0] pc[3];
    logic signed [31:0] cc[3];
    logic signed [32:0] d[3];
    logic [32:0]        mag[3];
    logic [69:0]        sumsq, t2;
    logic [33:0]        r, t;
    logic signed [35:0] dev;
    logic [65:0]        num, q;
    logic signed [34:0] v;
    logic signed [31:0] sv;
    logic               in_band, moved;
    res_t               o;
    pc[0] = p.pos_x; pc[1] = p.pos_y; pc[2] = p.pos_z;
    cc[0] = cen_x;   cc[1] = cen_y;   cc[2] = cen_z;
    sumsq = '0;
    for (int i = 0; i < DIMS; i++) begin
      d[i]   = $signed({pc[i][31], pc[i]}) - $signed({cc[i][31], cc[i]});
      mag[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      sumsq  = sumsq + 70'(mag[i]) * 70'(mag[i]);
    end
    // floor root, one bit at a time
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t  = r | (34'(1) << b);
      t2 = 70'(t) * 70'(t);
      if (t2 <= sumsq) r = t;
    end
    dev = $signed({2'b0, r}) - $signed({5'b0, radius});
    if (dev < 0) dev = -dev;
    in_band = dev <= $signed({5'b0, band});
    moved   = (sumsq != 0) && !in_band;
    o.out_x = p.pos_x;
    o.out_y = p.pos_y;
    o.out_z = p.pos_z;
    if (moved) begin
      for (int i = 0; i < DIMS; i++) begin
        num = 66'(mag[i]) * 66'(radius) * 2 + 66'(r);
        q   = num / (66'(r) * 2);
        if (d[i][32]) v = $signed({{3{cc[i][31]}}, cc[i]}) - $signed({2'b0, q[32:0]});
        else          v = $signed({{3{cc[i][31]}}, cc[i]}) + $signed({2'b0, q[32:0]});
        if (v > 35'sd2147483647)       sv = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648) sv = 32'sh80000000;
        else                           sv = v[31:0];
        case (i)
          0: o.out_x = sv;
          1: o.out_y = sv;
          default: o.out_z = sv;
        endcase
      end
    end
    o.moved       = moved;
    o.within_band = in_band;
    o.at_centre   = (sumsq == 0);
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", out_data.out_x, '0);
      end else begin
        e = pending_q.pop_front();
        if (out_data.out_x !== e.out_x) report("out_x", out_data.out_x, e.out_x);
        if (out_data.out_y !== e.out_y) report("out_y", out_data.out_y, e.out_y);
        if (out_data.out_z !== e.out_z) report("out_z", out_data.out_z, e.out_z);
        if (out_data.moved !== e.moved) report("moved", out_data.moved, e.moved);
        if (out_data.within_band !== e.within_band)
          report("within_band", out_data.within_band, e.within_band);
        if (out_data.at_centre !== e.at_centre)
          report("at_centre", out_data.at_centre, e.at_centre);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_MAX) begin
        $display("FAIL point_projection_onto_circle");
        $finish;
      end
    end
  end

  // Register write; cfg_we is lowered by the caller after the last one
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CENTRE_X: cen_x = val;
      REG_CENTRE_Y: cen_y = val;
      REG_CENTRE_Z: cen_z = val;
      REG_RADIUS:   radius = val[30:0];
      REG_MAX_DIST: band = val[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] cx, cy, cz, rr, mm);
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
    write_reg(REG_CENTRE_Z, cz);
    write_reg(REG_RADIUS, rr);
    write_reg(REG_MAX_DIST, mm);
    cfg_we <= 1'b0;
  endtask

  // One input transfer; start stays high for a following item
  task automatic send(pos_t p, bit typed, res_t r);
    in_data <= p;
    start   <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_q.push_back(typed ? r : project_point(p));
  endtask

  task automatic gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    gap(1);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Random point: mostly near the surface, some anywhere, some at or near the centre
  function automatic pos_t rand_point();
    pos_t p;
    int unsigned kind;
    logic signed [31:0] off, dlt;
    kind = $urandom_range(0, 9);
    p.pos_x = $urandom();
    p.pos_y = $urandom();
    p.pos_z = $urandom();
    dlt = $signed(32'($urandom_range(0, 2 * band + 4))) - $signed({1'b0, band}) - 2;
    off = $signed({1'b0, radius}) + dlt;
    if (kind <= 5) begin
      if ($urandom_range(0, 1)) off = -off;
      if (kind[0]) begin
        p.pos_x = cen_x + off;
        p.pos_y = cen_y + $signed(32'($urandom_range(0, 255))) - 128;
      end else begin
        p.pos_y = cen_y + off;
        p.pos_x = cen_x + $signed(32'($urandom_range(0, 255))) - 128;
      end
      if (DIMS == 3 && kind >= 4) begin
        p.pos_z = cen_z + off;
        p.pos_x = cen_x;
        p.pos_y = cen_y;
      end else if (DIMS == 3) begin
        p.pos_z = cen_z;
      end
    end else if (kind == 8) begin
      p.pos_x = cen_x;
      p.pos_y = cen_y;
      if (DIMS == 3) p.pos_z = cen_z;
    end else if (kind == 9) begin
      p.pos_x = cen_x + $signed(32'($urandom_range(0, 8191))) - 4096;
      p.pos_y = cen_y + $signed(32'($urandom_range(0, 8191))) - 4096;
    end
    return p;
  endfunction

  task automatic run_burst_items(int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send(rand_point(), 1'b0, '0);
      left -= burst;
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 9));
    end
  endtask

  function automatic row_t mk(logic [31:0] x, y, z, bit typed = 0,
                              logic [31:0] ex = 0, ey = 0, ez = 0,
                              bit mv = 0, bit wb = 0, bit ac = 0);
    row_t t;
    t.p = '{x, y, z};
    t.typed = typed;
    t.r = '{ex, ey, ez, mv, wb, ac};
    return t;
  endfunction

  initial begin
    logic [31:0] rr;
    cen_x = 0; cen_y = 0; cen_z = 0;
    radius = 31'd65536; band = 31'd65536;

    // Directed rows under the reset settings (unit circle, unit band)
    rows.push_back(mk(0, 0, 7, 1, 0, 0, 7, 0, 1, 1));
    rows.push_back(mk(32'h7FFFFFFF, 0, -1, 1, 65536, 0, -1, 1, 0, 0));
    rows.push_back(mk(32'h80000000, 0, 0, 1, -65536, 0, 0, 1, 0, 0));
    rows.push_back(mk(65536, 0, 0, 1, 65536, 0, 0, 0, 1, 0));
    rows.push_back(mk(0, 131073, 0, 1, 0, 65536, 0, 1, 0, 0));
    rows.push_back(mk(0, 131072, 0, 1, 0, 131072, 0, 0, 1, 0));
    rows.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000));
    rows.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    rows.push_back(mk(32'h7FFFFFFF, 32'h80000000, 32'h55555555));
    rows.push_back(mk(-1, -1, 32'hAAAAAAAA));
    rows.push_back(mk(1, 0, 0));
    rows.push_back(mk(0, -1, 0));
    rows.push_back(mk(-200000, 300000, 12345));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].p, rows[i].typed, rows[i].r);
    drain();

    // Extreme settings: saturation at both ends of the coordinate range
    set_config(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1);
    for (int i = 0; i < 6; i++) send(rand_point(), 1'b0, '0);
    send('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1'b0, '0);
    drain();
    set_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 32'h7FFFFFFF);
    send('{32'h80000000, 32'h80000000, 0}, 1'b0, '0);
    for (int i = 0; i < 4; i++) send(rand_point(), 1'b0, '0);
    drain();
    set_config(0, 0, 0, 1, 1);
    send('{32'h80000000, 32'h7FFFFFFF, 0}, 1'b0, '0);
    for (int i = 0; i < 4; i++) send(rand_point(), 1'b0, '0);
    drain();

    // Random phases with fresh settings each time
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case ($urandom_range(0, 2))
        0: rr = $urandom_range(1, 32'h0000FFFF);
        1: rr = $urandom_range(32'h00010000, 32'h01000000);
        default: rr = $urandom_range(1, 32'h7FFFFFFF);
      endcase
      set_config((ph == 0) ? 32'($urandom()) : 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000),
                 (ph == 0) ? 32'($urandom()) : 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000),
                 $urandom(), rr, $urandom_range(1, (ph % 2) ? 32'h7FFFFFFF : rr));
      run_burst_items(PHASE_LEN);
      drain();
    end

    repeat (PIPE_LAT + 8) @(posedge clk);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("PASS point_projection_onto_circle");
    end else begin
      $display("FAIL point_projection_onto_circle");
    end
    $finish;
  end

endmodule

### files.f
rtl/ppoc_pkg.sv
rtl/point_projection_onto_circle.sv
rtl/ppoc_checker.sv
sim/tb_point_projection_onto_circle.sv
